// File: hdl/json_string_unescape_macros.svh
// Assertion macros for the checker file of the string unescaper.
// No dependencies; included by bare file name.
`ifndef JSON_STRING_UNESCAPE_MACROS_SVH
`define JSON_STRING_UNESCAPE_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off while reset is asserted.
`define JSU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising edge, off while reset is asserted.
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/jsu_pkg.sv
// Shared types and constants of the JSON string unescaper.
// No dependencies; used by scoped names in every module of the block but jsu_fifo.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

	// result kinds
	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	// characters
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LOW_B  = 8'h62;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_T  = 8'h74;
	localparam logic [7:0] CH_LOW_U  = 8'h75;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_DIG_0  = 8'h30;
	localparam logic [7:0] CH_DIG_9  = 8'h39;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_F   = 8'h46;
	localparam logic [7:0] CH_LOW_A  = 8'h61;

	// \u codes below this give the code itself
	localparam logic [15:0] ASCII_LIMIT = 16'h0080;

	localparam logic [15:0] BUF_SIZE_RESET = 16'd256;

	// classified input byte
	typedef struct packed {
		logic       start;
		logic [7:0] raw;
		logic       is_nul;
		logic       is_quote;
		logic       is_bslash;
		logic       esc_ok;
		logic [7:0] esc_val;
		logic       is_u;
		logic       hex_ok;
		logic [3:0] hex_val;
	} tok_t;

	// one result item
	typedef struct packed {
		logic [7:0]  out_byte;
		logic [1:0]  kind;
		logic [15:0] char_count;
		logic        last;
	} res_t;

endpackage

`default_nettype wire

// File: hdl/jsu_fifo.sv
// Small first-in first-out queue used between the unescaper stages.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module jsu_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		if (p == AW'(DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/jsu_front.sv
// Front end of the unescaper: classifies each raw byte for the back end.
// Depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_front (
	input  wire logic       start_req,
	input  wire logic [7:0] in_byte,
	output jsu_pkg::tok_t   tok
);

	logic       is_dig;
	logic       is_up;
	logic       is_low;
	logic       esc_ok;
	logic [7:0] esc_val;

	assign is_dig = (in_byte >= jsu_pkg::CH_DIG_0) && (in_byte <= jsu_pkg::CH_DIG_9);
	assign is_up  = (in_byte >= jsu_pkg::CH_UP_A) && (in_byte <= jsu_pkg::CH_UP_F);
	assign is_low = (in_byte >= jsu_pkg::CH_LOW_A) && (in_byte <= jsu_pkg::CH_LOW_F);

	always_comb begin
		esc_ok  = 1'b1;
		esc_val = in_byte;
		unique case (in_byte) inside
			jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: begin
				esc_val = in_byte;
			end
			jsu_pkg::CH_LOW_B: esc_val = jsu_pkg::CH_BS;
			jsu_pkg::CH_LOW_F: esc_val = jsu_pkg::CH_FF;
			jsu_pkg::CH_LOW_N: esc_val = jsu_pkg::CH_LF;
			jsu_pkg::CH_LOW_R: esc_val = jsu_pkg::CH_CR;
			jsu_pkg::CH_LOW_T: esc_val = jsu_pkg::CH_TAB;
			default: begin
				esc_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		tok.start     = start_req;
		tok.raw       = in_byte;
		tok.is_nul    = (in_byte == jsu_pkg::CH_NUL);
		tok.is_quote  = (in_byte == jsu_pkg::CH_QUOTE);
		tok.is_bslash = (in_byte == jsu_pkg::CH_BSLASH);
		tok.esc_ok    = esc_ok;
		tok.esc_val   = esc_val;
		tok.is_u      = (in_byte == jsu_pkg::CH_LOW_U);
		tok.hex_ok    = is_dig || is_up || is_low;
		// letters of either case carry value low nibble plus nine
		tok.hex_val   = is_dig ? in_byte[3:0] : 4'(in_byte[3:0] + 4'd9);
	end

endmodule

`default_nettype wire

// File: hdl/jsu_back.sv
// Back end of the unescaper: string state machine and result generation.
// Depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [15:0]   buffer_size,
	input  wire logic          tok_avail,
	input  wire jsu_pkg::tok_t tok,
	output logic               tok_take,
	input  wire logic          res_full,
	output logic               res_push,
	output jsu_pkg::res_t      res
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_STR  = 2'd1;
	localparam logic [1:0] PH_ESC  = 2'd2;
	localparam logic [1:0] PH_HEX  = 2'd3;

	logic [1:0]  phase_q;
	logic [15:0] hex_acc_q;
	logic [1:0]  hex_cnt_q;
	logic [15:0] count_q;

	logic [1:0]  phase_d;
	logic [15:0] hex_acc_d;
	logic [1:0]  hex_cnt_d;
	logic [15:0] count_d;

	logic        go;
	logic        emit_req;
	logic [7:0]  emit_val;
	logic        fin_req;
	logic [1:0]  fin_kind;
	logic [15:0] hex_next;
	logic        room;

	assign go       = tok_avail && !res_full;
	assign tok_take = go;
	assign hex_next = {hex_acc_q[11:0], tok.hex_val};
	assign room     = ({1'b0, count_q} + 17'd1) < {1'b0, buffer_size};

	// classify the step into emit, finish or state-only update
	always_comb begin
		phase_d   = phase_q;
		hex_acc_d = hex_acc_q;
		hex_cnt_d = hex_cnt_q;
		emit_req  = 1'b0;
		emit_val  = tok.raw;
		fin_req   = 1'b0;
		fin_kind  = jsu_pkg::KIND_ERR;
		if (tok.start) begin
			hex_acc_d = '0;
			hex_cnt_d = '0;
			if (buffer_size == '0 || !tok.is_quote) begin
				fin_req = 1'b1;
			end else begin
				phase_d = PH_STR;
			end
		end else begin
			unique case (phase_q)
				PH_STR: begin
					if (tok.is_nul) begin
						fin_req = 1'b1;
					end else if (tok.is_quote) begin
						fin_req  = 1'b1;
						fin_kind = jsu_pkg::KIND_DONE;
					end else if (tok.is_bslash) begin
						phase_d = PH_ESC;
					end else begin
						emit_req = 1'b1;
					end
				end
				PH_ESC: begin
					if (tok.esc_ok) begin
						emit_req = 1'b1;
						emit_val = tok.esc_val;
					end else if (tok.is_u) begin
						hex_acc_d = '0;
						hex_cnt_d = '0;
						phase_d   = PH_HEX;
					end else begin
						fin_req = 1'b1;
					end
				end
				PH_HEX: begin
					if (!tok.hex_ok) begin
						fin_req = 1'b1;
					end else begin
						hex_acc_d = hex_next;
						if (hex_cnt_q != 2'd3) begin
							hex_cnt_d = hex_cnt_q + 2'd1;
						end else begin
							hex_cnt_d = '0;
							emit_req  = 1'b1;
							emit_val  = (hex_next < jsu_pkg::ASCII_LIMIT) ? hex_next[7:0]
								: jsu_pkg::CH_QMARK;
						end
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
		if (fin_req) begin
			phase_d = PH_IDLE;
		end
		if (emit_req) begin
			phase_d = PH_STR;
		end
	end

	// stored count and result payload
	always_comb begin
		count_d        = tok.start ? '0 : count_q;
		res_push       = 1'b0;
		res.out_byte   = '0;
		res.kind       = fin_kind;
		res.char_count = count_d;
		res.last       = 1'b0;
		if (fin_req) begin
			res_push = go;
			res.last = 1'b1;
		end else if (emit_req && room) begin
			count_d        = count_q + 16'd1;
			res_push       = go;
			res.out_byte   = emit_val;
			res.kind       = jsu_pkg::KIND_CHAR;
			res.char_count = count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			hex_acc_q <= '0;
			hex_cnt_q <= '0;
			count_q   <= '0;
		end else if (go) begin
			phase_q   <= phase_d;
			hex_acc_q <= hex_acc_d;
			hex_cnt_q <= hex_cnt_d;
			count_q   <= count_d;
		end
	end

endmodule

`default_nettype wire

// File: hdl/json_string_unescape.sv
// JSON string unescaper, top level: byte queue in, result queue out.
// Depends on jsu_pkg, jsu_front, jsu_fifo and jsu_back.
//
// Usage:
//   Input side is a queue: drive start_req and in_byte with push; a byte
//   transfers on a rising edge with push high and full low. Raise start_req
//   on the opening quote of each value; it abandons any value in progress.
//   Result side is a queue: while empty is low, out_byte, kind, char_count
//   and last show the oldest result; it transfers on an edge with pop high.
//   kind 0 is a decoded character, 1 ends the string (char_count = length),
//   2 ends a malformed value; last marks both ends. Bytes past the buffer
//   limit (buffer_size - 1 characters) and bytes outside a value give no
//   result.
//   Configuration: cfg_we with cfg_data writes buffer_size; write only idle.
// Timing:
//   A byte is classified on entry and queued; the back end decodes it from
//   the head of the input queue and pushes its result into the result queue.
//   Throughput is one byte per cycle while the result queue is not full, set
//   by the state update in the back end. When pop stays low the result queue
//   fills, the back end holds, then the input queue fills and full rises.
// Reset: both queues empty, state idle, buffer_size back to 256.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape #(
	parameter int CMD_DEPTH = 2,
	parameter int RES_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        start_req,
	input  wire logic [7:0]  in_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic      [7:0]  out_byte,
	output logic      [1:0]  kind,
	output logic      [15:0] char_count,
	output logic             last,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_data
);

	localparam int TOK_W = $bits(jsu_pkg::tok_t);
	localparam int RES_W = $bits(jsu_pkg::res_t);

	logic [15:0]        buffer_size_q;
	jsu_pkg::tok_t      tok_in;
	logic [TOK_W-1:0]   tok_raw;
	jsu_pkg::tok_t      tok_out;
	logic               cmd_empty;
	logic               tok_take;
	logic               res_full;
	logic               res_push;
	jsu_pkg::res_t      res_in;
	logic [RES_W-1:0]   res_raw;
	jsu_pkg::res_t      res_out;

	// buffer size register; hold between writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_size_q <= jsu_pkg::BUF_SIZE_RESET;
		end else if (cfg_we) begin
			buffer_size_q <= cfg_data;
		end
	end

	// classify the incoming byte
	jsu_front u_front (
		.start_req (start_req),
		.in_byte   (in_byte),
		.tok       (tok_in)
	);

	// queue classified bytes so front and back stall independently
	jsu_fifo #(
		.WIDTH (TOK_W),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (tok_in),
		.full    (full),
		.rd_en   (tok_take),
		.rd_data (tok_raw),
		.empty   (cmd_empty)
	);

	assign tok_out = jsu_pkg::tok_t'(tok_raw);

	// decode one token per cycle while the result queue has room
	jsu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.buffer_size (buffer_size_q),
		.tok_avail   (!cmd_empty),
		.tok         (tok_out),
		.tok_take    (tok_take),
		.res_full    (res_full),
		.res_push    (res_push),
		.res         (res_in)
	);

	// results wait here until popped
	jsu_fifo #(
		.WIDTH (RES_W),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_raw),
		.empty   (empty)
	);

	assign res_out    = jsu_pkg::res_t'(res_raw);
	assign out_byte   = res_out.out_byte;
	assign kind       = res_out.kind;
	assign char_count = res_out.char_count;
	assign last       = res_out.last;

endmodule

`default_nettype wire

// File: hdl/jsu_checker.sv
// Port-level checker for the JSON string unescaper, bound to the top level.
// Depends on jsu_pkg and json_string_unescape_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "json_string_unescape_macros.svh"

module jsu_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        empty,
	input wire logic        pop,
	input wire logic [7:0]  out_byte,
	input wire logic [1:0]  kind,
	input wire logic [15:0] char_count,
	input wire logic        last
);

	`JSU_ASSERT_NOW(a_kind_legal, clk, arst_n, !empty, (kind == jsu_pkg::KIND_CHAR || kind == jsu_pkg::KIND_DONE || kind == jsu_pkg::KIND_ERR), "result kind out of range")

	`JSU_ASSERT_NOW(a_last_on_end, clk, arst_n, !empty, (last == (kind != jsu_pkg::KIND_CHAR)), "last does not match an ending kind")

	`JSU_ASSERT_NOW(a_end_no_byte, clk, arst_n, !empty && kind != jsu_pkg::KIND_CHAR, (out_byte == 8'h00), "ending result carries a byte")

	`JSU_ASSERT_NOW(a_char_counted, clk, arst_n, !empty && kind == jsu_pkg::KIND_CHAR, (char_count != 16'd0), "character result with zero count")

	`JSU_ASSERT_NEXT(a_stall_hold, clk, arst_n, !empty && !pop, (!empty && $stable(out_byte) && $stable(kind) && $stable(char_count)), "stalled result changed")

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.out_byte   (out_byte),
	.kind       (kind),
	.char_count (char_count),
	.last       (last)
);

`default_nettype wire
